@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions in the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hw/rtl/rdiv64_pkg.sv @@
// ----------------------------------------------------------------------------
// rdiv64_pkg
// Types and constants shared by the pipelined restoring divider.
// ----------------------------------------------------------------------------
package rdiv64_pkg;

   // Operand and result width.
   localparam int DATA_WIDTH = 64;

   // Depth of the result path in stages: one sign stage, one stage per
   // quotient bit, one fix-up stage.
   localparam int LATENCY = DATA_WIDTH + 2;

   // One division request.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] dividend;
      logic [DATA_WIDTH-1:0] divisor;
      logic                  is_signed;
   } req_type;

   // One division result.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] quotient;
      logic [DATA_WIDTH-1:0] remainder;
   } rsp_type;

   // Working state carried down the step pipeline. The dividend bits still
   // to be consumed sit at the top of num_quo and the quotient bits fill in
   // from the bottom.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] rem;
      logic [DATA_WIDTH-1:0] num_quo;
      logic [DATA_WIDTH-1:0] den;
      logic                  neg_quo;
      logic                  neg_rem;
   } work_type;

endpackage

@@ hw/rtl/rdiv64_step.sv @@
// ----------------------------------------------------------------------------
// rdiv64_step
// One registered restoring division step: shifts the next dividend bit into
// the partial remainder, subtracts the divisor when it fits, records the bit.
// ----------------------------------------------------------------------------
module rdiv64_step (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  rdiv64_pkg::work_type in_work,
   output logic                 out_valid,
   output rdiv64_pkg::work_type out_work
);
   import rdiv64_pkg::*;

   logic                  carry;
   logic [DATA_WIDTH-1:0] shifted;
   logic [DATA_WIDTH+1:0] diff;
   logic                  take;
   work_type              work_in;
   work_type              work_ff;
   logic                  valid_ff;

   // Shift and trial subtract. The bit shifted out of the remainder makes the
   // shifted value at least the divisor, so it forces a subtraction.
   always_comb begin
      carry   = in_work.rem[DATA_WIDTH-1];
      shifted = {in_work.rem[DATA_WIDTH-2:0], in_work.num_quo[DATA_WIDTH-1]};
      diff    = {1'b0, carry, shifted} - {2'b00, in_work.den};
      take    = ~diff[DATA_WIDTH+1];
      work_in = in_work;
      work_in.rem     = take ? diff[DATA_WIDTH-1:0] : shifted;
      work_in.num_quo = {in_work.num_quo[DATA_WIDTH-2:0], take};
   end

   // Valid bit is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

`include "assert_macros.svh"

   // The partial remainder always stays below a nonzero divisor.
   `ASSERT_IMPL(a_rem_below_den, clock, reset, valid_ff && (work_ff.den != '0), work_ff.rem < work_ff.den)

endmodule

@@ hw/rtl/restoring_divider_64.sv @@
// ----------------------------------------------------------------------------
// restoring_divider_64
// Fully pipelined radix-2 restoring divider for signed and unsigned 64-bit
// operands, giving a truncating quotient and a remainder with the dividend's
// sign.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Handshake
//   request   start, busy, req_data          transfer when start && !busy
//   response  rsp_valid, rsp_data            one-cycle strobe, no back-pressure
//
// A new request can be taken in every cycle outside reset; the pipeline never stalls.
// The result path has one sign stage, 64 step stages (one quotient bit
// each, set by the 66-bit trial subtract), and one sign fix-up stage.
// busy is high only while reset is held, so no request is taken then.
// Reset clears the valid bits of all stages; data in flight is dropped.
//
module restoring_divider_64 (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rdiv64_pkg::req_type req_data,
   output logic                rsp_valid,
   output rdiv64_pkg::rsp_type rsp_data
);
   import rdiv64_pkg::*;

   logic                  accept;
   logic                  dvd_neg;
   logic                  dvs_neg;
   logic [DATA_WIDTH-1:0] dvd_mag;
   logic [DATA_WIDTH-1:0] dvs_mag;
   work_type              prep_in;
   work_type              pipe_work  [0:DATA_WIDTH];
   logic                  pipe_valid [0:DATA_WIDTH];
   work_type              prep_ff;
   logic                  prep_valid_ff;
   rsp_type               rsp_in;
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;
   work_type              last_work;

   assign busy   = reset;
   assign accept = start && !busy;

   // Sign stage: take magnitudes and note which results need negation.
   always_comb begin
      dvd_neg = req_data.is_signed && req_data.dividend[DATA_WIDTH-1];
      dvs_neg = req_data.is_signed && req_data.divisor[DATA_WIDTH-1];
      dvd_mag = dvd_neg ? (~req_data.dividend + DATA_WIDTH'(1)) : req_data.dividend;
      dvs_mag = dvs_neg ? (~req_data.divisor + DATA_WIDTH'(1)) : req_data.divisor;
      prep_in.rem     = '0;
      prep_in.num_quo = dvd_mag;
      prep_in.den     = dvs_mag;
      prep_in.neg_quo = dvd_neg ^ dvs_neg;
      prep_in.neg_rem = dvd_neg;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else begin
         prep_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
   end

   assign pipe_work[0]  = prep_ff;
   assign pipe_valid[0] = prep_valid_ff;

   // Step pipeline: one quotient bit per stage, most significant first.
   for (genvar gi = 0; gi < DATA_WIDTH; gi++) begin : g_step
      rdiv64_step u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[gi]),
         .in_work   (pipe_work[gi]),
         .out_valid (pipe_valid[gi+1]),
         .out_work  (pipe_work[gi+1])
      );
   end

   // Fix-up stage: apply the result signs.
   assign last_work = pipe_work[DATA_WIDTH];

   always_comb begin
      rsp_in.quotient  = last_work.neg_quo ? (~last_work.num_quo + DATA_WIDTH'(1))
                                           : last_work.num_quo;
      rsp_in.remainder = last_work.neg_rem ? (~last_work.rem + DATA_WIDTH'(1))
                                           : last_work.rem;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_valid[DATA_WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`include "assert_macros.svh"

   // Every response has a matching earlier transfer in.
   `ASSERT_IMPL(a_rsp_has_req, clock, reset, rsp_valid, $past(accept, LATENCY))
   // Every transfer in yields its response.
   `ASSERT_IMPL(a_req_gets_rsp, clock, reset, $past(accept, LATENCY), rsp_valid)
   // Unsigned requests never get a sign correction.
   `ASSERT_NEXT(a_unsigned_no_neg, clock, reset, accept && !req_data.is_signed, !prep_ff.neg_quo && !prep_ff.neg_rem)
   // A signed request with a negative dividend always negates the remainder.
   `ASSERT_NEXT(a_neg_rem_flag, clock, reset, accept && req_data.is_signed && req_data.dividend[DATA_WIDTH-1], prep_ff.neg_rem)

endmodule
